// File: design/lzwc_pkg.sv
`timescale 1ns / 1ps
package lzwc_pkg;
    localparam int CODE_BITS  = 12;
    localparam int OUT_BITS   = 12;
    localparam int ROOT_COUNT = 256;
    localparam logic [CODE_BITS-1:0] CLEAR_CODE = CODE_BITS'(ROOT_COUNT);
    localparam logic [CODE_BITS-1:0] MAX_CODE   = {CODE_BITS{1'b1}};

    // One trie node: byte of the edge into it, head of its child list,
    // next sibling in its parent's child list. Zero marks an empty link.
    typedef struct packed {
        logic [7:0]           byte_val;
        logic [CODE_BITS-1:0] child;
        logic [CODE_BITS-1:0] sib;
    } t_node;

    localparam int NODE_BITS = $bits(t_node);

    typedef enum logic [3:0] {
        S_IDLE, S_P_WAIT, S_C_WAIT, S_E_MISS, S_E_CLR,
        S_WR_NEW, S_WR_PAR, S_FIN, S_E_FPRE, S_E_END
    } t_state;
endpackage

// File: design/lzwc_ram.sv
`timescale 1ns / 1ps
module lzwc_ram #(
    parameter int DW = 32,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/lzw_compressor_12bit_unit.sv
`timescale 1ns / 1ps
// LZW encoder, 12-bit codes with clear code; dictionary kept as a
// child/sibling trie in one single-port-write RAM with registered read.
// Bytes are taken in idle, one at a time. A miss emits the prefix, then links a new
// node, or emits clear when full; a final byte then emits the prefix and an end
// marker. Output stalls hold the emit states.
// Reset (sync, active low): no pending string, code counter 256, root links gone.
module lzw_compressor_12bit_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] out_code, [15:12] zero
    output logic        m_axis_tuser,   // end_marker
    output logic        m_axis_tlast    // last_of_run
);
    import lzwc_pkg::*;

    t_state r_state, n_state;

    // String state
    logic [CODE_BITS-1:0]  r_prefix, n_prefix;
    logic                  r_pv, n_pv;
    logic [CODE_BITS-1:0]  r_next, n_next;
    logic [ROOT_COUNT-1:0] r_rv, n_rv;     // root child link is live
    // Current beat
    logic [7:0]            r_byte, n_byte;
    logic                  r_last, n_last;
    // Walk state
    t_node                 r_pword, n_pword;
    logic [CODE_BITS-1:0]  r_pchild, n_pchild;
    logic [CODE_BITS-1:0]  r_cur, n_cur;
    // Output register
    logic                  r_ovalid, n_ovalid;
    logic [OUT_BITS-1:0]   r_ocode, n_ocode;
    logic                  r_oend, n_oend;
    logic                  r_olast, n_olast;

    // RAM port
    logic                  ram_we;
    logic [CODE_BITS-1:0]  ram_waddr, ram_raddr;
    t_node                 ram_wdata, ram_rdata;
    logic [NODE_BITS-1:0]  ram_rbits;

    lzwc_ram #(.DW(NODE_BITS), .AW(CODE_BITS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );
    assign ram_rdata = t_node'(ram_rbits);

    logic slot_free;
    logic is_root;
    logic full;
    logic [CODE_BITS-1:0] head_child;

    assign slot_free = !r_ovalid || m_axis_tready;
    assign is_root   = (r_prefix < CODE_BITS'(ROOT_COUNT));
    assign full      = (r_next >= MAX_CODE);
    // A root whose link was dropped by a clear has no children
    assign head_child = (is_root && !r_rv[r_prefix[7:0]]) ? '0 : ram_rdata.child;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pv     <= 1'b0;
            r_next   <= CLEAR_CODE;
            r_rv     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pv     <= n_pv;
            r_next   <= n_next;
            r_rv     <= n_rv;
            r_ovalid <= n_ovalid;
        end
        r_prefix <= n_prefix;
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_pword  <= n_pword;
        r_pchild <= n_pchild;
        r_cur    <= n_cur;
        r_ocode  <= n_ocode;
        r_oend   <= n_oend;
        r_olast  <= n_olast;
    end

    always_comb begin
        n_state  = r_state;
        n_prefix = r_prefix;
        n_pv     = r_pv;
        n_next   = r_next;
        n_rv     = r_rv;
        n_byte   = r_byte;
        n_last   = r_last;
        n_pword  = r_pword;
        n_pchild = r_pchild;
        n_cur    = r_cur;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_ocode  = r_ocode;
        n_oend   = r_oend;
        n_olast  = r_olast;
        ram_we    = 1'b0;
        ram_waddr = r_prefix;
        ram_wdata = r_pword;
        ram_raddr = r_cur;
        s_axis_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                ram_raddr     = r_prefix;
                if (s_axis_tvalid) begin
                    n_byte = s_axis_tdata;
                    n_last = s_axis_tlast;
                    if (!r_pv) begin
                        // no pending string: the root starts one
                        n_prefix = CODE_BITS'(s_axis_tdata);
                        n_pv     = 1'b1;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_P_WAIT;
                    end
                end
            end
            S_P_WAIT: begin
                n_pword  = ram_rdata;
                n_pchild = head_child;
                if (head_child == '0) begin
                    n_state = S_E_MISS;
                end else begin
                    ram_raddr = head_child;
                    n_cur     = head_child;
                    n_state   = S_C_WAIT;
                end
            end
            S_C_WAIT: begin
                if (ram_rdata.byte_val == r_byte) begin
                    n_prefix = r_cur;
                    n_state  = S_FIN;
                end else if (ram_rdata.sib == '0) begin
                    n_state = S_E_MISS;
                end else begin
                    ram_raddr = ram_rdata.sib;
                    n_cur     = ram_rdata.sib;
                end
            end
            S_E_MISS: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_ocode  = OUT_BITS'(r_prefix);
                    n_oend   = 1'b0;
                    n_olast  = !full && !r_last;
                    n_state  = full ? S_E_CLR : S_WR_NEW;
                end
            end
            S_E_CLR: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_ocode  = OUT_BITS'(CLEAR_CODE);
                    n_oend   = 1'b0;
                    n_olast  = !r_last;
                    // drop the dictionary back to its roots
                    n_rv     = '0;
                    n_next   = CLEAR_CODE;
                    n_prefix = CODE_BITS'(r_byte);
                    n_state  = S_FIN;
                end
            end
            S_WR_NEW: begin
                // new node heads the parent's child list
                ram_we    = 1'b1;
                ram_waddr = r_next + 1'b1;
                ram_wdata = '{byte_val: r_byte, child: '0, sib: r_pchild};
                n_next    = r_next + 1'b1;
                n_state   = S_WR_PAR;
            end
            S_WR_PAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_prefix;
                ram_wdata = '{byte_val: r_pword.byte_val, child: r_next, sib: r_pword.sib};
                if (is_root) begin
                    n_rv[r_prefix[7:0]] = 1'b1;
                end
                n_prefix = CODE_BITS'(r_byte);
                n_state  = S_FIN;
            end
            S_FIN: begin
                n_state = r_last ? S_E_FPRE : S_IDLE;
            end
            S_E_FPRE: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_ocode  = OUT_BITS'(r_prefix);
                    n_oend   = 1'b0;
                    n_olast  = 1'b0;
                    n_state  = S_E_END;
                end
            end
            S_E_END: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_ocode  = '0;
                    n_oend   = 1'b1;
                    n_olast  = 1'b1;
                    // stream done: back to the reset state
                    n_pv     = 1'b0;
                    n_next   = CLEAR_CODE;
                    n_rv     = '0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0000, r_ocode};
    assign m_axis_tuser  = r_oend;
    assign m_axis_tlast  = r_olast;
endmodule

// File: tb/lzw_compressor_12bit_unit_tb.sv
`timescale 1ns / 1ps
module lzw_compressor_12bit_unit_tb;
    import lzwc_pkg::*;

    typedef struct packed {
        logic [11:0] code;
        logic        endm;
        logic        lastr;
    } t_code_beat;

    // Scoreboard: runs the dictionary itself and queues the expected code beats.
    class lzw_codebook;
        int unsigned   par_code [int unsigned];
        t_code_beat    pending[$];
        int unsigned   prefix;
        bit            have_prefix;
        int unsigned   top_code;
        int            errors;

        function void clear_dict();
            par_code.delete();
            prefix = 0;
            have_prefix = 0;
            top_code = 256;
        endfunction

        function void push_code(int unsigned c, bit e);
            t_code_beat b;
            b.code = c[11:0];
            b.endm = e;
            b.lastr = 1'b0;
            pending.push_back(b);
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            int unsigned key;
            int n0;
            n0 = pending.size();
            key = (prefix << 8) | b;
            if (!have_prefix) begin
                prefix = b;
                have_prefix = 1;
            end else if (par_code.exists(key)) begin
                prefix = par_code[key];
            end else begin
                push_code(prefix, 0);
                if (top_code >= 4095) begin
                    push_code(256, 0);
                    par_code.delete();
                    top_code = 256;
                end else begin
                    top_code++;
                    par_code[key] = top_code;
                end
                prefix = b;
            end
            if (fin) begin
                push_code(prefix, 0);
                push_code(0, 1);
                clear_dict();
            end
            if (pending.size() > n0)
                pending[pending.size()-1].lastr = 1'b1;
        endfunction

        function void check_beat(t_code_beat got);
            t_code_beat want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want !== got) begin
                $display("%0t: code beat mismatch exp code=%0d end=%b last=%b",
                    $realtime, want.code, want.endm, want.lastr);
                $display("%0t:                    act code=%0d end=%b last=%b",
                    $realtime, got.code, got.endm, got.lastr);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // final_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [11:0] out_code, [15:12] zero
    logic        m_axis_tuser;   // end_marker
    logic        m_axis_tlast;   // last_of_run

    lzw_codebook book;
    int          src_idle_pct;
    int          snk_idle_pct;

    lzw_compressor_12bit_unit uut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Sink: stall at random, check each accepted beat; upper code bits must be zero.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (m_axis_tdata[15:12] !== 4'b0) begin
                $display("%0t: pad bits exp 0 act %h", $realtime, m_axis_tdata[15:12]);
                book.errors++;
            end
            book.check_beat({m_axis_tdata[11:0], m_axis_tuser, m_axis_tlast});
        end
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Drive one byte beat; hold it until accepted, then note it in the scoreboard.
    // Valid stays up after acceptance; a drain, or an idle draw in the next send, drops it.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        book.note_byte(b, fin);
    endtask

    // Drop valid, wait for every queued code beat, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Send a stream drawn from the first alpha byte values; a small one makes strings repeat.
    task automatic send_stream(input int len, input int alpha);
        for (int k = 0; k < len; k++)
            send_byte(8'($urandom_range(alpha - 1)), k == len - 1);
    endtask

    initial begin
        int phase;
        book = new();
        book.clear_dict();
        book.errors = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        m_axis_tready = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: single-byte stream, extremes, repeats, miss then hit.
        send_byte(8'h00, 1);
        send_byte(8'hFF, 1);
        send_byte(8'hAA, 0); send_byte(8'h55, 0); send_byte(8'hAA, 0);
        send_byte(8'h55, 0); send_byte(8'hAA, 0); send_byte(8'h55, 1);
        for (int k = 0; k < 10; k++) send_byte(8'h41, k == 9);
        drain();

        // Two-byte stream ending on a miss.
        send_byte(8'h13, 0);
        send_byte(8'hC7, 1);
        drain();

        // Random streams under three idling phases.
        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 49 : 0;
            snk_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 7 : 0;
            for (int s = 0; s < 10; s++)
                send_stream($urandom_range(1, 18), ($urandom_range(3) == 0) ? 256 : 3);
            // Hold off until the block is fully drained.
            drain();
        end
        drain();

        if (book.errors == 0 && book.pending.size() == 0)
            $display("lzw_compressor_12bit_unit_tb: clean");
        else
            $display("lzw_compressor_12bit_unit_tb: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("lzw_compressor_12bit_unit_tb: errors");
        $finish;
    end
endmodule
